// ===== hdl/ising_pkg.sv =====
// Shared types and constants for the Ising Metropolis site-update block.
`default_nettype none
package ising_pkg;

  localparam int WIDTH_DEF     = 32;
  localparam int HEIGHT_DEF    = 32;
  localparam int PROB_BITS_DEF = 16;

  localparam int DIV_W        = 64;
  localparam int DIV_DIGIT    = 8;
  localparam int TAYLOR_TERMS = 13;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] KTEMP_Q32 = 32'd1365319963;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

  localparam logic [1:0] CFG_COUPLING_J = 2'd0;
  localparam logic [1:0] CFG_FIELD_H    = 2'd1;
  localparam logic [1:0] CFG_TEMP_LEVEL = 2'd2;

  localparam logic OP_TRIAL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic        op;
    logic [4:0]  site_x;
    logic [4:0]  site_y;
    logic [15:0] rand_uniform;
    logic        spin_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         out_x;
    logic [4:0]         out_y;
    logic               spin_after;
    logic               flipped;
    logic signed [19:0] delta_energy;
    logic [16:0]        accept_prob;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [3:0]       divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_GATHER,
    ST_ENERGY,
    ST_DECIDE,
    ST_MULA,
    ST_MULB,
    ST_DIVY,
    ST_WAITY,
    ST_RLO,
    ST_RHI,
    ST_TMUL,
    ST_TDIV,
    ST_TWAIT,
    ST_ROUND,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/ising_div.sv =====
// Iterative unsigned divider by a 4-bit divisor, eight quotient bits per cycle.
`default_nettype none
module ising_div
  import ising_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int STEPS = DIV_W / DIV_DIGIT;
  localparam int CW    = $clog2(STEPS);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [4:0]       rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    logic [4:0] t;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      t = {rem_nxt[3:0], q_nxt[DIV_W-1]};
      q_nxt = {q_nxt[DIV_W-2:0], (t >= {1'b0, req.divisor})};
      rem_nxt = (t >= {1'b0, req.divisor}) ? t - {1'b0, req.divisor} : t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== hdl/ising_metropolis_site_update.sv =====
// Top level: lattice memory, sequencer and fixed-point Metropolis datapath.
//
// Usage: drive in_item and pulse start while busy is low; the item is taken
// at that clock edge. A write item stores one spin; a trial item reads the
// site and its four wrapped neighbours, forms dE and the Boltzmann factor and
// flips the spin when rand_uniform falls below the acceptance probability.
// Each item yields one result on out_item, shown for one cycle with out_valid.
// The receiver cannot stall; results are never held.
// Run time depends on the item: a trial with dE <= 0 or zero level skips the
// exponential, as does one whose factor underflows. It is set by the shared
// 4-bit divider (once for the temperature and once for each of the 13 series
// terms) and the five one-port reads of the lattice memory.
// One item is in flight at a time; busy drops in the cycle its result is out.
// Configuration: cfg_valid/cfg_ready write coupling J, field h and the
// temperature level; cfg_ready is always high. Write only while idle.
// Reset: registers take their reset values, then the lattice memory is
// cleared one site a cycle (WIDTH*HEIGHT sites, 1024 by default) with busy
// high; configuration writes are taken during that pass.
`default_nettype none
module ising_metropolis_site_update
  import ising_pkg::*;
#(
  parameter int WIDTH     = WIDTH_DEF,
  parameter int HEIGHT    = HEIGHT_DEF,
  parameter int PROB_BITS = PROB_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int SITES = WIDTH * HEIGHT;
  localparam int AW    = $clog2(SITES);
  localparam int XW    = $clog2(WIDTH);
  localparam int YW    = $clog2(HEIGHT);
  localparam int ROWS  = (HEIGHT + 1) / 2;
  localparam int RB    = $clog2(ROWS);
  localparam int AMW   = 19 + RB;
  localparam int PMW   = AMW + 32;
  localparam int PBW   = PROB_BITS + 1;

  function automatic logic [10:0] wrap_coord(input logic [4:0] v, input int lim);
    logic [10:0] t;
    t = {6'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (t >= 11'(lim)) t = t - 11'(lim);
    end
    return t;
  endfunction

  function automatic logic [AW-1:0] site_addr(input logic [XW-1:0] xc,
                                              input logic [YW-1:0] yc);
    return AW'(AW'(yc) * AW'(WIDTH) + AW'(xc));
  endfunction

  // lattice memory
  logic          mem [SITES];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic          mem_wd;
  logic          mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_r <= mem[mem_addr];
  end

  // configuration
  logic signed [15:0] j_r;
  logic signed [15:0] h_r;
  logic [3:0]         lvl_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r   <= 16'sd4096;
      h_r   <= 16'sd0;
      lvl_r <= 4'd15;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUPLING_J: j_r   <= cfg_data;
        CFG_FIELD_H:    h_r   <= cfg_data;
        CFG_TEMP_LEVEL: lvl_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_t state_r, state_nxt;
  logic [AW-1:0]  clr_r;
  logic [2:0]     cnt_r;
  logic           rd_v_r;
  logic [2:0]     rd_idx_r;
  logic [4:0]     spins_r;

  logic [XW-1:0]  x_r;
  logic [YW-1:0]  y_r;
  logic [4:0]     ox_r, oy_r;
  logic [15:0]    rnd_r;
  logic           sv_r;

  logic signed [21:0] de_r;
  logic [AMW-1:0]     a_r;
  logic [PMW-1:0]     p_r;
  logic [4:0]         n_r;
  logic [23:0]        f_r;
  logic [39:0]        lo_r;
  logic [31:0]        r_r;
  logic [32:0]        term_r, sum_r, mp_r;
  logic [3:0]         k_r;
  logic [PBW-1:0]     prob_r;

  logic               out_valid_r;
  out_item_t          out_r;

  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;

  ising_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  logic accept_in;
  logic [10:0] in_xw, in_yw;
  logic [XW-1:0] xm, xp;
  logic [YW-1:0] ym, yp;
  logic [AW-1:0] pos;
  logic          flip_ok;

  assign accept_in = start && !busy;
  assign in_xw = wrap_coord(in_item.site_x, WIDTH);
  assign in_yw = wrap_coord(in_item.site_y, HEIGHT);
  assign xm = (x_r == '0) ? XW'(WIDTH - 1) : x_r - 1'b1;
  assign xp = (x_r == XW'(WIDTH - 1)) ? '0 : x_r + 1'b1;
  assign ym = (y_r == '0) ? YW'(HEIGHT - 1) : y_r - 1'b1;
  assign yp = (y_r == YW'(HEIGHT - 1)) ? '0 : y_r + 1'b1;
  assign pos = site_addr(x_r, y_r);
  assign flip_ok = ({1'b0, rnd_r, {PROB_BITS{1'b0}}} < {prob_r, 16'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_addr  = pos;
    mem_wd    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(mp_r);
    div_req.divisor  = k_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        if (clr_r == AW'(SITES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept_in) state_nxt = (in_item.op == OP_WRITE) ? ST_WRITE : ST_READ;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wd    = sv_r;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        unique case (cnt_r)
          3'd0:    mem_addr = pos;
          3'd1:    mem_addr = site_addr(x_r, ym);
          3'd2:    mem_addr = site_addr(xm, y_r);
          3'd3:    mem_addr = site_addr(xp, y_r);
          default: mem_addr = site_addr(x_r, yp);
        endcase
        if (cnt_r == 3'd4) state_nxt = ST_GATHER;
      end
      ST_GATHER: state_nxt = ST_ENERGY;
      ST_ENERGY: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (de_r <= 0 || lvl_r == '0) state_nxt = ST_FINISH;
        else                          state_nxt = ST_MULA;
      end
      ST_MULA: state_nxt = ST_MULB;
      ST_MULB: state_nxt = ST_DIVY;
      ST_DIVY: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(p_r[PMW-1:20]);
        div_req.divisor  = lvl_r;
        state_nxt        = ST_WAITY;
      end
      ST_WAITY: begin
        div_req.divisor = lvl_r;
        if (div_done) begin
          state_nxt = (div_q[DIV_W-1:29] != '0) ? ST_FINISH : ST_RLO;
        end
      end
      ST_RLO: state_nxt = ST_RHI;
      ST_RHI: state_nxt = ST_TMUL;
      ST_TMUL: state_nxt = ST_TDIV;
      ST_TDIV: begin
        div_req.start = 1'b1;
        state_nxt     = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_done) begin
          state_nxt = (k_r == 4'(TAYLOR_TERMS)) ? ST_ROUND : ST_TMUL;
        end
      end
      ST_ROUND: state_nxt = ST_FINISH;
      ST_FINISH: begin
        mem_we    = flip_ok;
        mem_wd    = ~spins_r[0];
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_v_r      <= (state_r == ST_READ);
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_READ)  cnt_r <= cnt_r + 1'b1;
      else                     cnt_r <= '0;
      if (state_r == ST_WRITE || state_r == ST_FINISH) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0]         ones;
    logic signed [3:0]  nsum;
    logic signed [19:0] jn;
    logic signed [21:0] e;
    logic [55:0]        rsum;
    logic [64:0]        tp;
    logic [5:0]         shamt;
    logic [32:0]        shv;
    logic [32:0]        rnd_v;
    ones  = 3'(spins_r[1]) + 3'(spins_r[2]) + 3'(spins_r[3]) + 3'(spins_r[4]);
    nsum  = signed'({ones, 1'b0}) - 4'sd4;
    jn    = j_r * nsum;
    e     = (22'(jn) <<< 1) - (22'(h_r) <<< 1);
    rsum  = 56'(lo_r) + {40'(f_r) * 40'(LN2_Q32[31:16]), 16'b0};
    tp    = term_r * r_r;
    shamt = 6'(31 - PROB_BITS) + 6'(n_r);
    shv   = sum_r >> shamt;
    rnd_v = (shv + 33'd1) >> 1;

    if (accept_in) begin
      x_r   <= XW'(in_xw);
      y_r   <= YW'(in_yw);
      ox_r  <= in_xw[4:0];
      oy_r  <= in_yw[4:0];
      rnd_r <= in_item.rand_uniform;
      sv_r  <= in_item.spin_value;
    end
    if (rd_v_r) spins_r[rd_idx_r] <= mem_rd_r;
    rd_idx_r <= cnt_r;

    unique case (state_r)
      ST_ENERGY: de_r <= spins_r[0] ? e : -e;
      ST_DECIDE: begin
        if (de_r <= 0) prob_r <= PBW'(1) << PROB_BITS;
        else           prob_r <= '0;
      end
      ST_MULA: a_r <= AMW'(de_r[18:0]) * AMW'(ROWS - 1);
      ST_MULB: p_r <= PMW'(a_r) * PMW'(KTEMP_Q32);
      ST_WAITY: begin
        n_r <= div_q[28:24];
        f_r <= div_q[23:0];
      end
      ST_RLO: lo_r <= 40'(f_r) * 40'(LN2_Q32[15:0]);
      ST_RHI: begin
        r_r    <= rsum[55:24];
        term_r <= ONE_Q32;
        sum_r  <= ONE_Q32;
        k_r    <= 4'd1;
      end
      ST_TMUL: mp_r <= tp[64:32];
      ST_TWAIT: begin
        if (div_done) begin
          term_r <= div_q[32:0];
          // odd terms subtract, even terms add
          if (k_r[0]) sum_r <= sum_r - div_q[32:0];
          else        sum_r <= sum_r + div_q[32:0];
          k_r <= k_r + 1'b1;
        end
      end
      ST_ROUND: prob_r <= PBW'(rnd_v);
      default: ;
    endcase

    if (state_r == ST_WRITE) begin
      out_r.out_x        <= ox_r;
      out_r.out_y        <= oy_r;
      out_r.spin_after   <= sv_r;
      out_r.flipped      <= 1'b0;
      out_r.delta_energy <= '0;
      out_r.accept_prob  <= '0;
    end else if (state_r == ST_FINISH) begin
      out_r.out_x        <= ox_r;
      out_r.out_y        <= oy_r;
      out_r.spin_after   <= spins_r[0] ^ flip_ok;
      out_r.flipped      <= flip_ok;
      out_r.delta_energy <= de_r[19:0];
      out_r.accept_prob  <= 17'(prob_r);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ===== tb/ising_metropolis_site_update_test.sv =====
// Self-checking testbench for the Ising Metropolis site-update block.
`timescale 1ns / 100ps
module ising_metropolis_site_update_test;
  import ising_pkg::*;

  localparam int SIDE = 32;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  ising_metropolis_site_update DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic               spins [SIDE*SIDE];
  logic signed [15:0] j_coupling;
  logic signed [15:0] h_field;
  logic [3:0]         t_level;

  in_item_t  pending_items [$];
  out_item_t expected_updates [$];
  int        mismatch_count;
  int        burst_left;
  int        gap_left;
  longint unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] boltzmann_factor(longint unsigned de, logic [3:0] lvl);
    longint unsigned y, n, f, r, sum, term;
    int sh;
    y = (de * 64'd15 * 64'(KTEMP_Q32)) / (64'(lvl) << 20);
    n = y >> 24;
    f = y & 64'hFFFFFF;
    if (n >= 32) return 17'd0;
    r = (f * 64'(LN2_Q32)) >> 24;
    sum = 64'(ONE_Q32);
    term = 64'(ONE_Q32);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * r) >> 32) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    sh = 16 + int'(n);
    return 17'((((sum >> (sh - 1)) + 1) >> 1));
  endfunction

  function automatic out_item_t site_update(in_item_t it);
    out_item_t res;
    int x, y, pos, s, nsum;
    longint de;
    logic [16:0] prob;
    x = it.site_x;
    y = it.site_y;
    pos = y * SIDE + x;
    res = '0;
    res.out_x = it.site_x;
    res.out_y = it.site_y;
    if (it.op == OP_WRITE) begin
      spins[pos] = it.spin_value;
    end else begin
      s = spins[pos] ? 1 : -1;
      nsum = (spins[((y + SIDE - 1) % SIDE) * SIDE + x] ? 1 : -1)
           + (spins[y * SIDE + (x + SIDE - 1) % SIDE] ? 1 : -1)
           + (spins[y * SIDE + (x + 1) % SIDE] ? 1 : -1)
           + (spins[((y + 1) % SIDE) * SIDE + x] ? 1 : -1);
      de = (2 * longint'(j_coupling) * nsum - 2 * longint'(h_field)) * s;
      if (de <= 0) prob = 17'h10000;
      else if (t_level == 0) prob = 17'd0;
      else prob = boltzmann_factor(longint'(de), t_level);
      if (17'(it.rand_uniform) < prob) begin
        spins[pos] = ~spins[pos];
        res.flipped = 1'b1;
      end
      res.delta_energy = 20'(de);
      res.accept_prob = prob;
    end
    res.spin_after = spins[pos];
    return res;
  endfunction

  // driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold the item until it is taken
    end else begin
      if (start) expected_updates.push_back(site_update(in_item));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_updates.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result %p", out_item);
      end else begin
        out_item_t want;
        want = expected_updates.pop_front();
        if (out_item.out_x !== want.out_x || out_item.out_y !== want.out_y ||
            out_item.spin_after !== want.spin_after ||
            out_item.flipped !== want.flipped ||
            out_item.delta_energy !== want.delta_energy ||
            out_item.accept_prob !== want.accept_prob) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: expected %p actual %p", want, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COUPLING_J: j_coupling = val;
      CFG_FIELD_H:    h_field = val;
      CFG_TEMP_LEVEL: t_level = val[3:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_items.size() > 0 || start || busy || expected_updates.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic op, int x, int y, int rnd, logic sv);
    in_item_t it;
    it.op = op;
    it.site_x = 5'(x);
    it.site_y = 5'(y);
    it.rand_uniform = 16'(rnd);
    it.spin_value = sv;
    return it;
  endfunction

  task automatic push_random(int count);
    int cx, cy;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        // write one random site so trials see mixed spins
        cx = $urandom_range(0, 31);
        cy = $urandom_range(0, 31);
        pending_items.push_back(make_item(OP_WRITE, cx, cy, $urandom_range(0, 65535),
                                          1'($urandom)));
      end else begin
        pending_items.push_back(make_item(OP_TRIAL, $urandom_range(0, 31),
                                          $urandom_range(0, 31), $urandom_range(0, 65535),
                                          1'($urandom)));
      end
    end
  endtask

  initial begin
    logic [15:0] j_set [8];
    logic [15:0] h_set [8];
    logic [3:0]  lvl_set [8];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    in_item = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gap_left = 0;
    foreach (spins[i]) spins[i] = 1'b0;
    j_coupling = 16'sd4096;
    h_field = 16'sd0;
    t_level = 4'd15;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners, both ops, rand extremes, default settings
    pending_items.push_back(make_item(OP_TRIAL, 0, 0, 0, 1'b1));
    pending_items.push_back(make_item(OP_TRIAL, 31, 31, 65535, 1'b0));
    pending_items.push_back(make_item(OP_WRITE, 0, 0, 65535, 1'b1));
    pending_items.push_back(make_item(OP_WRITE, 31, 0, 0, 1'b1));
    pending_items.push_back(make_item(OP_WRITE, 0, 31, 0, 1'b1));
    pending_items.push_back(make_item(OP_TRIAL, 0, 0, 0, 1'b0));
    pending_items.push_back(make_item(OP_TRIAL, 0, 0, 65535, 1'b0));
    pending_items.push_back(make_item(OP_WRITE, 31, 31, 0, 1'b0));
    pending_items.push_back(make_item(OP_TRIAL, 31, 31, 32768, 1'b1));
    pending_items.push_back(make_item(OP_TRIAL, 1, 0, 100, 1'b0));
    pending_items.push_back(make_item(OP_TRIAL, 5, 17, 65535, 1'b1));
    settle();
    // zero level: positive dE never flips
    write_reg(CFG_TEMP_LEVEL, 16'd0);
    pending_items.push_back(make_item(OP_TRIAL, 10, 10, 0, 1'b0));
    pending_items.push_back(make_item(OP_TRIAL, 10, 11, 0, 1'b0));
    pending_items.push_back(make_item(OP_TRIAL, 10, 10, 0, 1'b0));
    settle();

    j_set = '{16'h7FFF, 16'h8000, 16'd2048, 16'd4096, 16'h0400, 16'hF000, 16'd0, 16'h0}; 
    h_set = '{16'h8000, 16'h7FFF, 16'd0, 16'd1024, 16'hFC00, 16'd512, 16'h2000, 16'h0};
    lvl_set = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd12, 4'd0};
    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        j_set[p] = 16'($urandom_range(0, 8191)) - 16'd4096;
        h_set[p] = 16'($urandom_range(0, 4095)) - 16'd2048;
        lvl_set[p] = 4'($urandom_range(0, 15));
      end
      write_reg(CFG_COUPLING_J, j_set[p]);
      write_reg(CFG_FIELD_H, h_set[p]);
      write_reg(CFG_TEMP_LEVEL, 16'(lvl_set[p]));
      push_random(215);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ising_pkg.sv
hdl/ising_div.sv
hdl/ising_metropolis_site_update.sv
tb/ising_metropolis_site_update_test.sv
